FILE: design/pir_pkg.sv
package pir_pkg;

    localparam logic [31:0] SEAL_BASIS  = 32'd2166136261;
    localparam logic [31:0] SEAL_PRIME  = 32'd16777619;
    localparam logic [31:0] SHADOW_MASK = 32'hA5A5A5A5;
    localparam logic [31:0] FAULT_MASK  = 32'h00FF00FF;
    localparam logic [4:0]  ROT_ENC     = 5'd7;
    localparam logic [4:0]  ROT_KEY     = 5'd5;

    localparam logic [2:0] REQ_INIT     = 3'd0;
    localparam logic [2:0] REQ_SET      = 3'd1;
    localparam logic [2:0] REQ_GET      = 3'd2;
    localparam logic [2:0] REQ_VALIDATE = 3'd3;
    localparam logic [2:0] REQ_REKEY    = 3'd4;
    localparam logic [2:0] REQ_DEFAULT  = 3'd5;
    localparam logic [2:0] REQ_FAULT    = 3'd6;

    localparam logic [2:0] WHY_NONE    = 3'd0;
    localparam logic [2:0] WHY_NOINIT  = 3'd1;
    localparam logic [2:0] WHY_SEAL    = 3'd2;
    localparam logic [2:0] WHY_SHADOW  = 3'd3;
    localparam logic [2:0] WHY_RANGE   = 3'd4;

    localparam logic [2:0] CFG_ENC      = 3'd0;
    localparam logic [2:0] CFG_RANGE_EN = 3'd1;
    localparam logic [2:0] CFG_MIN      = 3'd2;
    localparam logic [2:0] CFG_MAX      = 3'd3;
    localparam logic [2:0] CFG_FALLBACK = 3'd4;
    localparam logic [2:0] CFG_RECOVERY = 3'd5;

    localparam logic [1:0] REC_RESTORE = 2'd0;
    localparam logic [1:0] REC_CLAMP   = 2'd1;

    localparam logic [3:0] DP_NOP   = 4'd0;
    localparam logic [3:0] DP_LOAD  = 4'd1;
    localparam logic [3:0] DP_INIT  = 4'd2;
    localparam logic [3:0] DP_FIRST = 4'd3;
    localparam logic [3:0] DP_SETV  = 4'd4;
    localparam logic [3:0] DP_DEFV  = 4'd5;
    localparam logic [3:0] DP_FAULT = 4'd6;
    localparam logic [3:0] DP_HASH  = 4'd7;
    localparam logic [3:0] DP_EVAL  = 4'd8;
    localparam logic [3:0] DP_REKEY = 4'd9;
    localparam logic [3:0] DP_ENC   = 4'd10;
    localparam logic [3:0] DP_SEAL  = 4'd11;
    localparam logic [3:0] DP_RVG   = 4'd12;
    localparam logic [3:0] DP_OUT   = 4'd13;

    typedef struct packed {
        logic [3:0] op;
        logic [1:0] hidx;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] req;
        logic       ready;
        logic       need_store;
        logic       out_free;
    } dp_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] s);
        logic [5:0] r;
        r = 6'd32 - {1'b0, s};
        return (x << s) | (x >> r);
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] s);
        logic [5:0] r;
        r = 6'd32 - {1'b0, s};
        return (x >> s) | (x << r);
    endfunction

    function automatic logic [31:0] clamp(input logic [31:0] v, input logic [31:0] lo,
                                          input logic [31:0] hi);
        if ($signed(v) < $signed(lo))
            return lo;
        else if ($signed(v) < $signed(hi))
            return v;
        else
            return hi;
    endfunction

endpackage

FILE: design/pir_datapath.sv
module pir_datapath
    import pir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  dp_cmd_t     cmd,
    output dp_stat_t    stat,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [31:0] cfg_wdata,
    input  logic [2:0]  in_req,
    input  logic [31:0] in_wv,
    input  logic [31:0] in_key,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_rv,
    output logic        out_ok,
    output logic [2:0]  out_reason,
    output logic [31:0] out_total
);

    logic [1:0]  enc_reg, rec_reg;
    logic        ren_reg;
    logic [31:0] min_reg, max_reg, fb_reg;
    logic [31:0] masked_reg, shadow_reg, key_reg, seal_reg, good_reg, cnt_reg;
    logic        ready_reg;
    logic [2:0]  reason_reg;
    logic [2:0]  req_reg;
    logic [31:0] wv_reg, fk_reg, sv_reg, rv_reg, h_reg;
    logic        ok_reg;
    logic        oval_reg;
    logic [31:0] h_next, h_op, dec, enc, rec_v;
    logic [2:0]  why;

    always_comb
    begin
        case (cmd.hidx)
            2'd0:    h_op = SEAL_BASIS ^ masked_reg;
            2'd1:    h_op = h_reg ^ shadow_reg;
            default: h_op = h_reg ^ key_reg;
        endcase
        h_next = h_op * SEAL_PRIME;
    end

    always_comb
    begin
        case (enc_reg)
            2'd0:    dec = masked_reg ^ key_reg;
            2'd1:    dec = rotr(masked_reg, {1'b0, key_reg[3:0]}) ^ key_reg;
            2'd2:    dec = (masked_reg ^ rotr(key_reg, ROT_KEY)) - key_reg;
            default: dec = rotr(masked_reg, ROT_ENC) - key_reg;
        endcase
        case (enc_reg)
            2'd0:    enc = sv_reg ^ key_reg;
            2'd1:    enc = rotl(sv_reg ^ key_reg, {1'b0, key_reg[3:0]});
            2'd2:    enc = (sv_reg + key_reg) ^ rotr(key_reg, ROT_KEY);
            default: enc = rotl(sv_reg + key_reg, ROT_ENC);
        endcase
    end

    always_comb
    begin
        if (!ready_reg)
            why = WHY_NOINIT;
        else if (h_reg != seal_reg)
            why = WHY_SEAL;
        else if (dec != (shadow_reg ^ SHADOW_MASK))
            why = WHY_SHADOW;
        else if (ren_reg && ($signed(dec) < $signed(min_reg) ||
                             $signed(dec) > $signed(max_reg)))
            why = WHY_RANGE;
        else
            why = WHY_NONE;
        case (rec_reg)
            REC_RESTORE: rec_v = good_reg;
            REC_CLAMP:   rec_v = ren_reg ? clamp(good_reg, min_reg, max_reg) : good_reg;
            default:     rec_v = fb_reg;
        endcase
    end

    assign stat.req        = req_reg;
    assign stat.ready      = ready_reg;
    assign stat.need_store = (why != WHY_NONE) && (why != WHY_NOINIT);
    assign stat.out_free   = !oval_reg || out_ready;
    assign out_valid       = oval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg    <= 2'd0;
            ren_reg    <= 1'b0;
            min_reg    <= 32'h80000000;
            max_reg    <= 32'h7FFFFFFF;
            fb_reg     <= 32'd0;
            rec_reg    <= 2'd2;
            masked_reg <= 32'd0;
            shadow_reg <= 32'd0;
            key_reg    <= 32'd0;
            seal_reg   <= 32'd0;
            good_reg   <= 32'd0;
            cnt_reg    <= 32'd0;
            ready_reg  <= 1'b0;
            reason_reg <= WHY_NONE;
            oval_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_idx)
                    CFG_ENC:      enc_reg <= cfg_wdata[1:0];
                    CFG_RANGE_EN: ren_reg <= cfg_wdata[0];
                    CFG_MIN:      min_reg <= cfg_wdata;
                    CFG_MAX:      max_reg <= cfg_wdata;
                    CFG_FALLBACK: fb_reg  <= cfg_wdata;
                    CFG_RECOVERY: rec_reg <= cfg_wdata[1:0];
                    default:      ;
                endcase
            end
            if (oval_reg && out_ready && cmd.op != DP_OUT)
                oval_reg <= 1'b0;
            unique case (cmd.op)
                DP_INIT:
                begin
                    key_reg    <= fk_reg;
                    ready_reg  <= 1'b1;
                    reason_reg <= WHY_NONE;
                end
                DP_FIRST:
                begin
                    if (!ready_reg)
                    begin
                        key_reg    <= fk_reg;
                        ready_reg  <= 1'b1;
                        reason_reg <= WHY_NONE;
                    end
                end
                DP_SETV:
                begin
                    good_reg   <= ren_reg ? clamp(wv_reg, min_reg, max_reg) : wv_reg;
                    reason_reg <= WHY_NONE;
                end
                DP_DEFV:
                begin
                    good_reg   <= fb_reg;
                    reason_reg <= WHY_NONE;
                end
                DP_FAULT: masked_reg <= masked_reg ^ FAULT_MASK;
                DP_EVAL:
                begin
                    if (why != WHY_NONE)
                    begin
                        cnt_reg    <= cnt_reg + 32'd1;
                        reason_reg <= why;
                        if (req_reg != REQ_VALIDATE && why != WHY_NOINIT)
                            good_reg <= rec_v;
                    end
                end
                DP_REKEY: key_reg <= fk_reg;
                DP_ENC:
                begin
                    masked_reg <= enc;
                    shadow_reg <= sv_reg ^ SHADOW_MASK;
                end
                DP_SEAL: seal_reg <= h_reg;
                DP_OUT:  oval_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                req_reg <= in_req;
                wv_reg  <= in_wv;
                fk_reg  <= in_key;
                ok_reg  <= 1'b0;
            end
            DP_SETV: sv_reg <= ren_reg ? clamp(wv_reg, min_reg, max_reg) : wv_reg;
            DP_DEFV: sv_reg <= fb_reg;
            DP_HASH: h_reg  <= h_next;
            DP_EVAL:
            begin
                ok_reg <= (why == WHY_NONE);
                sv_reg <= rec_v;
                if (req_reg == REQ_VALIDATE)
                    rv_reg <= good_reg;
                else if (why == WHY_NOINIT)
                    rv_reg <= fb_reg;
                else if (why == WHY_NONE)
                    rv_reg <= dec;
                else
                    rv_reg <= rec_v;
            end
            DP_REKEY: sv_reg <= rv_reg;
            DP_RVG:   rv_reg <= good_reg;
            DP_OUT:
            begin
                out_rv     <= rv_reg;
                out_ok     <= ok_reg;
                out_reason <= reason_reg;
                out_total  <= cnt_reg;
            end
            default: ;
        endcase
    end

endmodule

FILE: design/pir_ctrl.sv
module pir_ctrl
    import pir_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DISP = 4'd1;
    localparam logic [3:0] S_SETV = 4'd2;
    localparam logic [3:0] S_DEFV = 4'd3;
    localparam logic [3:0] S_ENC  = 4'd4;
    localparam logic [3:0] S_STH  = 4'd5;
    localparam logic [3:0] S_SEAL = 4'd6;
    localparam logic [3:0] S_RVG  = 4'd7;
    localparam logic [3:0] S_CHK  = 4'd8;
    localparam logic [3:0] S_EVAL = 4'd9;
    localparam logic [3:0] S_REKY = 4'd10;
    localparam logic [3:0] S_OUT  = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [1:0] step_reg, step_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = DP_NOP;
        cmd.hidx   = step_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.op     = DP_LOAD;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                step_next = 2'd0;
                case (stat.req)
                    REQ_INIT:
                    begin
                        cmd.op     = DP_INIT;
                        state_next = S_SETV;
                    end
                    REQ_SET:
                    begin
                        cmd.op     = DP_FIRST;
                        state_next = S_SETV;
                    end
                    REQ_GET, REQ_VALIDATE: state_next = S_CHK;
                    REQ_REKEY: state_next = stat.ready ? S_CHK : S_RVG;
                    REQ_DEFAULT:
                    begin
                        cmd.op     = DP_FIRST;
                        state_next = S_DEFV;
                    end
                    REQ_FAULT:
                    begin
                        cmd.op     = DP_FAULT;
                        state_next = S_RVG;
                    end
                    default: state_next = S_RVG;
                endcase
            end
            S_SETV:
            begin
                cmd.op     = DP_SETV;
                state_next = S_ENC;
            end
            S_DEFV:
            begin
                cmd.op     = DP_DEFV;
                state_next = S_ENC;
            end
            S_ENC:
            begin
                cmd.op     = DP_ENC;
                step_next  = 2'd0;
                state_next = S_STH;
            end
            S_STH:
            begin
                cmd.op    = DP_HASH;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                    state_next = S_SEAL;
            end
            S_SEAL:
            begin
                cmd.op     = DP_SEAL;
                state_next = (stat.req == REQ_REKEY) ? S_OUT : S_RVG;
            end
            S_RVG:
            begin
                cmd.op     = DP_RVG;
                state_next = S_OUT;
            end
            S_CHK:
            begin
                cmd.op    = DP_HASH;
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd2)
                    state_next = S_EVAL;
            end
            S_EVAL:
            begin
                cmd.op = DP_EVAL;
                if (stat.req == REQ_REKEY)
                    state_next = S_REKY;
                else if (stat.req == REQ_GET && stat.need_store)
                    state_next = S_ENC;
                else
                    state_next = S_OUT;
            end
            S_REKY:
            begin
                cmd.op     = DP_REKEY;
                state_next = S_ENC;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = DP_OUT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

endmodule

FILE: design/protected_int_register.sv
// Protected signed 32-bit register.
// Requests arrive on the s_ stream: tuser carries req_type, tdata carries
// write_value and fresh_key. Every request gives one result transfer on the
// m_ stream: read_value, check_ok, last_reason and tamper_total.
// Configuration registers are written on the cfg_ channel (always ready);
// the user is to write them only while the block is idle: the block itself
// does not enforce this. Index 0..5 select encoding, range enable, range
// min, range max, fallback value and recovery mode. Other indexes are ignored.
// One request is processed at a time. The seal is a three-word hash run over
// one shared multiplier, one word per cycle, once for a check and once for a
// store. Fault injection, unknown requests and rekey before init skip the
// hash; get or validate run the check; init, set and reset to default run the
// store; rekey or a recovering get run the check and then the store.
// The result sits in an output register; s_tready rises again as soon as the
// result is written there, and a stalled receiver holds the next result back.
// Reset clears the stored value, key, seal and counter, returns the
// configuration to its defaults, and leaves the block uninitialized.
module protected_int_register
    import pir_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,  // write_value[31:0], fresh_key[63:32]
    input  logic [2:0]  s_tuser,  // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // read_value[31:0], check_ok[32], last_reason[35:33],
                                  // tamper_total[67:36], zero[71:68]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [31:0] rv, total;
    logic        ok;
    logic [2:0]  reason;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {4'd0, total, reason, ok, rv};

    pir_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pir_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .cfg_we     (cfg_valid),
        .cfg_idx    (cfg_index),
        .cfg_wdata  (cfg_data),
        .in_req     (s_tuser),
        .in_wv      (s_tdata[31:0]),
        .in_key     (s_tdata[63:32]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_rv     (rv),
        .out_ok     (ok),
        .out_reason (reason),
        .out_total  (total)
    );

endmodule

FILE: design/pir_checker.sv
module pir_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [71:0] m_tdata
);

    logic [31:0] last_total_reg;
    logic        seen_reg;
    logic        xfer;

    assign xfer = m_tvalid && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_total_reg <= 32'd0;
            seen_reg       <= 1'b0;
        end
        else if (xfer)
        begin
            last_total_reg <= m_tdata[67:36];
            seen_reg       <= 1'b1;
        end
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> (m_tdata[67:36] == last_total_reg ||
                  m_tdata[67:36] == last_total_reg + 32'd1))
        else $error("tamper count jumped");

    a_ok_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        xfer && m_tdata[32] |-> m_tdata[67:36] == last_total_reg)
        else $error("passing check counted a tamper");

    a_reason: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:33] != 3'd5 && m_tdata[35:33] != 3'd6 &&
                      m_tdata[35:33] != 3'd7))
        else $error("bad reason code");

    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:68] == 4'd0)
        else $error("padding not zero");

endmodule

bind protected_int_register pir_checker u_pir_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
